FILE: hdl/assert_macros.svh
// Assertion macros used by the decoder RTL.
// Include with the bare file name; each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// The expression must never be true at a clock edge while reset is released.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

FILE: hdl/u8sd_pkg.sv
// Package for the UTF-8 stream decoder: channel word types, the control
// bundles between controller and datapath, constants and the lead-byte decoder.
// No dependencies.
`timescale 1ns / 1ps

package u8sd_pkg;

    // Input word: one raw byte plus the end-of-text flag.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_final;
    } t_in_word;

    // Output word: one code point plus the end-of-run flag.
    typedef struct packed {
        logic [20:0] code_point;
        logic        last_of_run;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // take the input word into the pending buffer
        logic step;   // commit one decode step and load the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emit;       // the current decode step yields a code point
        logic last;       // that code point ends the run for this byte
        logic slot_free;  // the output register can take a word this cycle
    } t_dp_status;

    localparam logic [20:0] ReplCp   = 21'h00FFFD;
    localparam logic [2:0]  BufDepth = 3'd4;
    localparam logic [1:0]  LastStep = 2'd3;

    // Sequence length announced by a lead byte: 1 for ASCII, 2 to 4 for
    // multi-byte leads, 0 for a byte that cannot start a sequence.
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        priority if (b < 8'h80) begin
            len = 3'd1;
        end else if ((b & 8'hE0) == 8'hC0) begin
            len = 3'd2;
        end else if ((b & 8'hF0) == 8'hE0) begin
            len = 3'd3;
        end else if ((b & 8'hF8) == 8'hF0) begin
            len = 3'd4;
        end else begin
            len = 3'd0;
        end
        return len;
    endfunction

endpackage

FILE: hdl/u8sd_ctrl.sv
// Controller of the UTF-8 stream decoder: takes input words and sequences
// the decode steps. Depends on u8sd_pkg.
`timescale 1ns / 1ps

module u8sd_ctrl
    import u8sd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state r_state;
    logic   r_in_ready;

    // Commands: load on an accepted word, step when a result can be placed.
    always_comb begin
        o_cmd.load = i_in_valid && r_in_ready;
        o_cmd.step = (r_state == S_RUN) && i_status.emit && i_status.slot_free;
    end

    assign o_in_ready = r_in_ready;

    // State and registered ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state    <= S_RUN;
                        r_in_ready <= 1'b0;
                    end
                end
                S_RUN: begin
                    // Finish when the decode yields no result, or on the last result.
                    if (!i_status.emit || (i_status.slot_free && i_status.last)) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

endmodule

FILE: hdl/u8sd_dpath.sv
// Datapath of the UTF-8 stream decoder: pending byte buffer, one-step
// decoder, front shifter and output register. Depends on u8sd_pkg.
`timescale 1ns / 1ps

module u8sd_dpath
    import u8sd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  t_in_word   i_in_data,
    input  logic       i_out_ready,
    output t_dp_status o_status,
    output logic       o_out_valid,
    output t_out_word  o_out_data
);

    logic [7:0]  r_buf [4];
    logic [2:0]  r_cnt;
    logic        r_final;
    logic [1:0]  r_n;
    logic        r_out_valid;
    t_out_word   r_out_data;

    logic [7:0]  lead;
    logic [2:0]  len;
    logic        ok1, ok2, ok3;
    logic        emit;
    logic [20:0] cp;
    logic [2:0]  drop;
    logic [2:0]  rem_cnt;
    logic [7:0]  next_front;
    logic [2:0]  next_len;
    logic        next_stall;
    logic        last;
    logic [7:0]  shifted [4];

    // Decode the sequence at the front of the buffer.
    always_comb begin
        lead = r_buf[0];
        len  = lead_len(lead);
        ok1  = (r_buf[1][7:6] == 2'b10);
        ok2  = (r_buf[2][7:6] == 2'b10);
        ok3  = (r_buf[3][7:6] == 2'b10);
        emit = 1'b0;
        cp   = ReplCp;
        drop = 3'd1;
        priority if (r_cnt == 3'd0) begin
            emit = 1'b0;
        end else if (len == 3'd1) begin
            emit = 1'b1;
            cp   = {13'd0, lead};
        end else if (len == 3'd0) begin
            emit = 1'b1;
        end else if (len > r_cnt) begin
            // Short sequence: wait for more bytes unless the text has ended.
            emit = r_final;
        end else begin
            emit = 1'b1;
            priority if (!ok1) begin
                drop = 3'd1;
            end else if ((len >= 3'd3) && !ok2) begin
                drop = 3'd2;
            end else if ((len == 3'd4) && !ok3) begin
                drop = 3'd3;
            end else begin
                drop = len;
                unique case (len)
                    3'd2:    cp = {10'd0, lead[4:0], r_buf[1][5:0]};
                    3'd3:    cp = {5'd0, lead[3:0], r_buf[1][5:0], r_buf[2][5:0]};
                    default: cp = {lead[2:0], r_buf[1][5:0], r_buf[2][5:0],
                                   r_buf[3][5:0]};
                endcase
            end
        end
    end

    // Look ahead: does the run end after this step?
    always_comb begin
        rem_cnt = r_cnt - drop;
        unique case (drop)
            3'd1:    next_front = r_buf[1];
            3'd2:    next_front = r_buf[2];
            3'd3:    next_front = r_buf[3];
            default: next_front = r_buf[0];
        endcase
        next_len   = lead_len(next_front);
        next_stall = (next_len >= 3'd2) && (next_len > rem_cnt) && !r_final;
        last       = (rem_cnt == 3'd0) || (r_n == LastStep) || next_stall;
    end

    // Shift the buffer forward by the number of consumed bytes.
    always_comb begin
        shifted = r_buf;
        unique case (drop)
            3'd1: begin
                shifted[0] = r_buf[1];
                shifted[1] = r_buf[2];
                shifted[2] = r_buf[3];
            end
            3'd2: begin
                shifted[0] = r_buf[2];
                shifted[1] = r_buf[3];
            end
            3'd3: begin
                shifted[0] = r_buf[3];
            end
            default: begin
                shifted = r_buf;
            end
        endcase
    end

    always_comb begin
        o_status.emit      = emit;
        o_status.last      = last;
        o_status.slot_free = !r_out_valid || i_out_ready;
    end

    // Pending byte storage: append on load, shift on step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_cnt < BufDepth)) begin
            r_buf[r_cnt[1:0]] <= i_in_data.data_byte;
        end else if (i_cmd.step) begin
            r_buf <= shifted;
        end
    end

    // Control state of the datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= 3'd0;
            r_final     <= 1'b0;
            r_n         <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (r_cnt < BufDepth) begin
                    r_cnt <= r_cnt + 3'd1;
                end
                r_final <= i_in_data.is_final;
                r_n     <= 2'd0;
            end else if (i_cmd.step) begin
                r_cnt <= rem_cnt;
                r_n   <= r_n + 2'd1;
            end
            if (i_cmd.step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_out_data.code_point  <= cp;
            r_out_data.last_of_run <= last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: hdl/utf8_stream_decoder.sv
// UTF-8 stream decoder: bytes in, code points out.
// Usage:
//   Input channel i_in_valid / o_in_ready carries one word: a byte of text
//   and is_final, set on the last byte of a text to flush pending bytes.
//   Output channel o_out_valid / i_out_ready carries one word per code point;
//   last_of_run marks the last code point caused by an input byte. A byte
//   that only extends an open sequence yields no output word.
//   An accepted byte enters the pending buffer; each decode step then loads
//   one code point into the output register. A byte yields 0 to 4 code
//   points, and the next byte is accepted only once its decode steps are
//   done. The single decode unit produces one code point per cycle into the
//   output register while the receiver takes the words.
//   A stalled receiver halts decoding; the next byte is still accepted
//   while the final word of the previous byte waits in the output register.
//   Reset (synchronous, active low) empties the pending buffer and the
//   output register; no clearing pass is needed.
// Depends on u8sd_pkg, u8sd_ctrl, u8sd_dpath and assert_macros.svh.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module utf8_stream_decoder
    import u8sd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Sequencer.
    u8sd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // Buffer, decoder and output register.
    u8sd_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // A result word never overwrites one the receiver has not taken.
    `ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n,
        dp_cmd.step && o_out_valid && !i_out_ready,
        "decode step overwrote a pending output word")
    // Ready is low in the cycle after a word is taken.
    `ASSERT_CLK(a_busy_after_load, i_clk, i_rst_n,
        (i_in_valid && o_in_ready) |=> !o_in_ready,
        "input ready stayed high after a word was accepted")
    // The last result of a run returns the decoder to accepting input.
    `ASSERT_CLK(a_last_frees, i_clk, i_rst_n,
        (dp_cmd.step && dp_status.last) |=> (o_in_ready && o_out_valid && o_out_data.last_of_run),
        "last result of a run did not release the input")

endmodule
